// ===== hw/rtl/fbpnf_pkg.sv =====
package fbpnf_pkg;

   localparam int MAX_SLOTS_DEF      = 256;
   localparam int FLAG_WORD_BITS_DEF = 32;

   localparam logic [8:0]  SLOT_COUNT_RST = 9'd256;
   localparam logic [15:0] BODY_LIMIT_RST = 16'd32;

   typedef enum logic {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_TOO_BIG  = 2'd1,
      STAT_FULL     = 2'd2,
      STAT_BAD_FREE = 2'd3
   } status_type;

   typedef enum logic {
      CSR_SLOT_COUNT = 1'b0,
      CSR_BODY_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_FREE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic        action;
      logic [15:0] request_size;
      logic [7:0]  slot_index;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] granted_slot;
      logic [8:0] busy_total;
   } rsp_type;

endpackage

// ===== hw/rtl/fixed_block_pool_next_fit.sv =====
// Fixed-size slot pool allocator with next-fit search. Each request transaction is an
// allocate or a free and yields exactly one response transaction carrying status,
// granted slot and the busy count after the operation. Busy flags live in a small RAM
// of FLAG_WORD_BITS-bit words (8 words by default); one word-scan unit with a priority
// encoder walks them, one word per cycle. An allocate refused on size, or on a pool of
// zero slots, is answered from the start state; otherwise the scan visits words from the
// next-fit pointer, wrapping once, until a free slot is found or the pool is full. A free
// reads its flag word and bit, found by a reciprocal multiply, and clears the bit if set; an
// out-of-range free is answered from the start state. One transaction is in flight at a
// time and a new one is taken only once the response register is free. After reset the
// flag RAM is swept clear, one word per cycle, during which requests are stalled; CSR
// writes are taken at any time but must only be issued while the block is idle.
module fixed_block_pool_next_fit
   import fbpnf_pkg::*;
#(
   parameter int MAX_SLOTS      = MAX_SLOTS_DEF,
   parameter int FLAG_WORD_BITS = FLAG_WORD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int NUM_WORDS = (MAX_SLOTS + FLAG_WORD_BITS - 1) / FLAG_WORD_BITS;
   localparam int WW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int BW        = (FLAG_WORD_BITS > 1) ? $clog2(FLAG_WORD_BITS) : 1;
   localparam int SW        = $clog2(NUM_WORDS * FLAG_WORD_BITS + 2 * FLAG_WORD_BITS + 512);
   // slot_index / FLAG_WORD_BITS as a multiply by a rounded-up reciprocal, exact for 8 bits
   localparam int RECIP_SH  = 8 + BW;
   localparam int PW        = 8 + RECIP_SH + 1;

   localparam logic [SW-1:0] FWB_S     = SW'(FLAG_WORD_BITS);
   localparam logic [SW-1:0] MAX_S     = SW'(MAX_SLOTS);
   localparam logic [WW-1:0] LAST_WORD = WW'(NUM_WORDS - 1);
   localparam logic [BW-1:0] LAST_BIT  = BW'(FLAG_WORD_BITS - 1);
   localparam logic [PW-1:0] RECIP_P   =
      PW'((2 ** RECIP_SH + FLAG_WORD_BITS - 1) / FLAG_WORD_BITS);

   state_type            state_ff, state_in;
   req_type              req_ff, req_in;
   logic [WW-1:0]        word_ff, word_in;
   logic [SW-1:0]        base_ff, base_in;
   logic                 wrapped_ff, wrapped_in;
   logic [SW-1:0]        start_slot_ff, start_slot_in;
   logic [WW-1:0]        start_word_ff, start_word_in;
   logic [SW-1:0]        next_slot_ff, next_slot_in;
   logic [WW-1:0]        next_word_ff, next_word_in;
   logic [SW-1:0]        next_base_ff, next_base_in;
   logic [BW-1:0]        bit_ff, bit_in;
   logic [8:0]           busy_count_ff, busy_count_in;
   logic [WW-1:0]        clr_word_ff, clr_word_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic [8:0]           slot_count_ff;
   logic [15:0]          body_limit_ff;

   logic                 req_accept;
   logic [SW-1:0]        eff_n;
   logic                 size_fail;
   logic                 ptr_ok;
   logic                 free_range_bad;
   logic [SW-1:0]        idx_s;
   logic [PW-1:0]        free_prod;
   logic [SW-1:0]        free_q;
   logic [WW-1:0]        free_word;
   logic [BW-1:0]        free_bit;

   logic [FLAG_WORD_BITS-1:0] cand;
   logic                 found;
   logic [BW-1:0]        found_bit;
   logic [SW-1:0]        found_slot;
   logic [SW-1:0]        found_slot_p1;
   logic                 last_word;
   logic [SW-1:0]        bit_slot;

   logic                 ram_we;
   logic [WW-1:0]        ram_waddr;
   logic [FLAG_WORD_BITS-1:0] ram_wdata;
   logic [WW-1:0]        ram_raddr;
   logic [FLAG_WORD_BITS-1:0] ram_rdata;

   logic                 done;
   logic [1:0]           done_status;

   fbpnf_flag_ram #(
      .WORD_BITS (FLAG_WORD_BITS),
      .DEPTH     (NUM_WORDS)
   ) u_flag_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_stall  = !((state_ff == ST_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // shared word-scan unit and request checks
   always_comb begin
      eff_n          = (SW'(slot_count_ff) > MAX_S) ? MAX_S : SW'(slot_count_ff);
      size_fail      = req_ff.request_size > body_limit_ff;
      ptr_ok         = next_slot_ff < eff_n;
      idx_s          = SW'(req_ff.slot_index);
      free_range_bad = idx_s >= eff_n;
      free_prod      = PW'(req_ff.slot_index) * RECIP_P;
      free_q         = SW'(free_prod >> RECIP_SH);
      free_word      = WW'(free_q);
      free_bit       = BW'(idx_s - free_q * FWB_S);
      last_word      = (base_ff + FWB_S) >= eff_n;
      for (int b = 0; b < FLAG_WORD_BITS; b++) begin
         bit_slot = base_ff + SW'(b);
         if (wrapped_ff) begin
            cand[b] = !ram_rdata[b] && (bit_slot < start_slot_ff);
         end else begin
            cand[b] = !ram_rdata[b] && (bit_slot >= start_slot_ff) && (bit_slot < eff_n);
         end
      end
      found     = |cand;
      found_bit = '0;
      for (int b = FLAG_WORD_BITS - 1; b >= 0; b--) begin
         if (cand[b]) begin
            found_bit = BW'(b);
         end
      end
      found_slot    = base_ff + SW'(found_bit);
      found_slot_p1 = found_slot + SW'(1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_word_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (req_ff.action == ACT_ALLOC) begin
               state_in = (size_fail || (eff_n == '0)) ? ST_IDLE : ST_SCAN;
            end else begin
               state_in = free_range_bad ? ST_IDLE : ST_FREE;
            end
         end
         ST_FREE: begin
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (found) begin
               state_in = ST_IDLE;
            end else if (!wrapped_ff && last_word && (start_slot_ff == '0)) begin
               state_in = ST_IDLE;
            end else if (wrapped_ff && (word_ff == start_word_ff)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath, RAM port and response
   always_comb begin
      req_in        = req_ff;
      word_in       = word_ff;
      base_in       = base_ff;
      wrapped_in    = wrapped_ff;
      start_slot_in = start_slot_ff;
      start_word_in = start_word_ff;
      next_slot_in  = next_slot_ff;
      next_word_in  = next_word_ff;
      next_base_in  = next_base_ff;
      bit_in        = bit_ff;
      busy_count_in = busy_count_ff;
      clr_word_in   = clr_word_ff;
      ram_we        = 1'b0;
      ram_waddr     = word_ff;
      ram_wdata     = ram_rdata;
      ram_raddr     = word_ff;
      done          = 1'b0;
      done_status   = STAT_OK;
      rsp_in        = rsp_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_word_ff;
            ram_wdata   = '0;
            clr_word_in = clr_word_ff + WW'(1);
         end
         ST_IDLE: begin
            if (req_accept) begin
               req_in = req_data;
            end
         end
         ST_START: begin
            wrapped_in = 1'b0;
            if (req_ff.action == ACT_ALLOC) begin
               if (size_fail) begin
                  done        = 1'b1;
                  done_status = STAT_TOO_BIG;
               end else if (eff_n == '0) begin
                  done        = 1'b1;
                  done_status = STAT_FULL;
               end else begin
                  word_in       = ptr_ok ? next_word_ff : '0;
                  base_in       = ptr_ok ? next_base_ff : '0;
                  start_slot_in = ptr_ok ? next_slot_ff : '0;
                  start_word_in = ptr_ok ? next_word_ff : '0;
                  ram_raddr     = ptr_ok ? next_word_ff : '0;
               end
            end else begin
               word_in   = free_word;
               bit_in    = free_bit;
               ram_raddr = free_word;
               if (free_range_bad) begin
                  done        = 1'b1;
                  done_status = STAT_BAD_FREE;
               end
            end
         end
         ST_FREE: begin
            done = 1'b1;
            if (ram_rdata[bit_ff]) begin
               ram_we        = 1'b1;
               ram_waddr     = word_ff;
               ram_wdata     = ram_rdata & ~(FLAG_WORD_BITS'(1) << bit_ff);
               busy_count_in = busy_count_ff - 9'd1;
               done_status   = STAT_OK;
            end else begin
               done_status = STAT_BAD_FREE;
            end
         end
         ST_SCAN: begin
            if (found) begin
               done          = 1'b1;
               done_status   = STAT_OK;
               ram_we        = 1'b1;
               ram_waddr     = word_ff;
               ram_wdata     = ram_rdata | (FLAG_WORD_BITS'(1) << found_bit);
               busy_count_in = busy_count_ff + 9'd1;
               if (found_slot_p1 >= eff_n) begin
                  next_slot_in = '0;
                  next_word_in = '0;
                  next_base_in = '0;
               end else if (found_bit == LAST_BIT) begin
                  next_slot_in = found_slot_p1;
                  next_word_in = word_ff + WW'(1);
                  next_base_in = base_ff + FWB_S;
               end else begin
                  next_slot_in = found_slot_p1;
                  next_word_in = word_ff;
                  next_base_in = base_ff;
               end
            end else if (!wrapped_ff && last_word && (start_slot_ff == '0)) begin
               done        = 1'b1;
               done_status = STAT_FULL;
            end else if (wrapped_ff && (word_ff == start_word_ff)) begin
               done        = 1'b1;
               done_status = STAT_FULL;
            end else if (!wrapped_ff && last_word) begin
               wrapped_in = 1'b1;
               word_in    = '0;
               base_in    = '0;
               ram_raddr  = '0;
            end else begin
               word_in   = word_ff + WW'(1);
               base_in   = base_ff + FWB_S;
               ram_raddr = word_ff + WW'(1);
            end
         end
         default: ;
      endcase

      if (done) begin
         rsp_in.status       = done_status;
         rsp_in.granted_slot = (done_status == STAT_OK && state_ff == ST_SCAN) ?
                               found_slot[7:0] : 8'd0;
         rsp_in.busy_total   = busy_count_in;
      end
      rsp_valid_in = done || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_word_ff   <= '0;
         next_slot_ff  <= '0;
         next_word_ff  <= '0;
         next_base_ff  <= '0;
         busy_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         wrapped_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_word_ff   <= clr_word_in;
         next_slot_ff  <= next_slot_in;
         next_word_ff  <= next_word_in;
         next_base_ff  <= next_base_in;
         busy_count_ff <= busy_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         wrapped_ff    <= wrapped_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      word_ff       <= word_in;
      base_ff       <= base_in;
      start_slot_ff <= start_slot_in;
      start_word_ff <= start_word_in;
      bit_ff        <= bit_in;
      rsp_ff        <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= SLOT_COUNT_RST;
         body_limit_ff <= BODY_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SLOT_COUNT: slot_count_ff <= csr_wdata[8:0];
            CSR_BODY_LIMIT: body_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      busy_count_ff <= 9'(MAX_SLOTS > 511 ? 511 : MAX_SLOTS))
      else $error("busy count above pool size");

   a_fail_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.status == STAT_OK || rsp_ff.granted_slot == 8'd0))
      else $error("failed transaction carries a slot");

   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_START || $past(state_ff) == ST_FREE ||
                               $past(state_ff) == ST_SCAN))
      else $error("response raised outside a working state");

endmodule

// ===== hw/rtl/fbpnf_flag_ram.sv =====
module fbpnf_flag_ram
   import fbpnf_pkg::*;
#(
   parameter int WORD_BITS = FLAG_WORD_BITS_DEF,
   parameter int DEPTH     = (MAX_SLOTS_DEF + FLAG_WORD_BITS_DEF - 1) / FLAG_WORD_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WORD_BITS-1:0]                   wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WORD_BITS-1:0]                   rd_data
);

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/sv/tb_fixed_block_pool_next_fit.sv =====
`timescale 1ns / 100ps

module tb_fixed_block_pool_next_fit;
   import fbpnf_pkg::*;

   // tracks the pool as the block should see it and holds the responses still owed
   class slot_pool_tracker;
      bit [MAX_SLOTS_DEF-1:0] busy_map;
      int unsigned next_ptr;
      int unsigned busy_cnt;
      int unsigned slot_regs;
      int unsigned size_limit;
      rsp_type owed_responses[$];
      bit failed;

      function new();
         busy_map = '0;
         next_ptr = 0;
         busy_cnt = 0;
         slot_regs = SLOT_COUNT_RST;
         size_limit = BODY_LIMIT_RST;
         failed = 1'b0;
      endfunction

      function void set_register(csr_index_type idx, logic [15:0] value);
         if (idx == CSR_SLOT_COUNT) begin
            slot_regs = value[8:0];
         end else begin
            size_limit = value;
         end
      endfunction

      function rsp_type predict_outcome(req_type r);
         rsp_type o;
         int unsigned n;
         int unsigned start;
         int unsigned s;
         int unsigned k;
         bit found;
         n = (slot_regs > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : slot_regs;
         o = '0;
         o.status = STAT_OK;
         found = 1'b0;
         if (r.action == ACT_ALLOC) begin
            if (r.request_size > size_limit) begin
               o.status = STAT_TOO_BIG;
            end else begin
               // next-fit: pointer past the live range restarts at slot 0
               start = (next_ptr < n) ? next_ptr : 0;
               for (k = 0; k < n && !found; k++) begin
                  s = start + k;
                  if (s >= n) s -= n;
                  if (!busy_map[s]) begin
                     busy_map[s] = 1'b1;
                     o.granted_slot = 8'(s);
                     next_ptr = (s + 1 >= n) ? 0 : s + 1;
                     busy_cnt++;
                     found = 1'b1;
                  end
               end
               if (!found) o.status = STAT_FULL;
            end
         end else if (r.slot_index >= n || !busy_map[r.slot_index]) begin
            o.status = STAT_BAD_FREE;
         end else begin
            busy_map[r.slot_index] = 1'b0;
            busy_cnt--;
         end
         o.busy_total = 9'(busy_cnt);
         return o;
      endfunction

      function void note_request(req_type r);
         owed_responses.push_back(predict_outcome(r));
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (owed_responses.size() == 0) begin
            $display("%0t: unexpected response st=%0d slot=%0d busy=%0d", $time,
                     got.status, got.granted_slot, got.busy_total);
            failed = 1'b1;
            return;
         end
         want = owed_responses.pop_front();
         if (got !== want) begin
            $display("%0t: expected st=%0d slot=%0d busy=%0d, got st=%0d slot=%0d busy=%0d",
                     $time, want.status, want.granted_slot, want.busy_total,
                     got.status, got.granted_slot, got.busy_total);
            failed = 1'b1;
         end
      endfunction

      function int unsigned pending();
         return owed_responses.size();
      endfunction

      function int unsigned any_busy_slot();
         int unsigned hits[$];
         for (int i = 0; i < MAX_SLOTS_DEF; i++) begin
            if (busy_map[i]) hits.push_back(i);
         end
         if (hits.size() == 0) return $urandom_range(0, 255);
         return hits[$urandom_range(0, hits.size() - 1)];
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [15:0] csr_wdata = '0;

   bit steady = 1'b0;
   bit hold_request = 1'b0;
   slot_pool_tracker pool;

   int unsigned phase_slots [8] = '{256, 1, 8, 300, 2, 511, 40, 256};
   int unsigned phase_limit [8] = '{32, 65535, 100, 0, 1000, 65535, 16, 32};
   int unsigned phase_alloc [8] = '{70, 60, 55, 50, 60, 65, 55, 45};

   fixed_block_pool_next_fit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // valid stays high when the next transaction follows straight on
   task automatic send_request(input req_type item);
      int unsigned gap;
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      pool.note_request(item);
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic issue(input action_type act, input int unsigned size, input int unsigned idx);
      req_type item;
      item.action = act;
      item.request_size = 16'(size);
      item.slot_index = 8'(idx);
      send_request(item);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pool.pending() != 0);
   endtask

   task automatic write_csr(input csr_index_type idx, input int unsigned value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 16'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      pool.set_register(idx, 16'(value));
      @(posedge clock);
   endtask

   initial begin : response_side
      int unsigned stall_left;
      int unsigned hold_left;
      int unsigned r;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) pool.check_response(rsp_data);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 400;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            r = $urandom_range(0, 99);
            if (steady || r < 60) begin
               stall_left = 0;
            end else if (r < 93) begin
               stall_left = $urandom_range(1, 3);
            end else begin
               stall_left = $urandom_range(8, 40);
            end
         end
      end
   end

   initial begin : request_side
      int unsigned p;
      int unsigned i;
      int unsigned lim;
      int unsigned size;
      int unsigned idx;
      action_type act;
      pool = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // defaults: limit edge, oversize, bad frees, next-fit skips a freed slot
      issue(ACT_ALLOC, 0, 0);
      issue(ACT_ALLOC, 32, 0);
      issue(ACT_ALLOC, 33, 0);
      issue(ACT_ALLOC, 65535, 255);
      issue(ACT_FREE, 65535, 255);
      issue(ACT_FREE, 0, 0);
      issue(ACT_FREE, 0, 0);
      issue(ACT_ALLOC, 0, 0);
      drain();

      // shrink to two slots: pointer out of range, slot 2 stranded above the count
      write_csr(CSR_SLOT_COUNT, 2);
      write_csr(CSR_BODY_LIMIT, 0);
      issue(ACT_ALLOC, 0, 0);
      issue(ACT_ALLOC, 1, 0);
      issue(ACT_ALLOC, 0, 0);
      issue(ACT_FREE, 0, 2);
      issue(ACT_FREE, 0, 1);
      issue(ACT_ALLOC, 0, 0);
      drain();

      // empty pool, size check wins over full
      write_csr(CSR_SLOT_COUNT, 0);
      issue(ACT_ALLOC, 0, 0);
      issue(ACT_ALLOC, 5, 0);
      issue(ACT_FREE, 0, 0);
      drain();

      // count above the pool size is clamped
      write_csr(CSR_SLOT_COUNT, 511);
      write_csr(CSR_BODY_LIMIT, 65535);
      issue(ACT_ALLOC, 65535, 0);
      issue(ACT_FREE, 0, 255);
      issue(ACT_FREE, 0, 170);
      issue(ACT_FREE, 0, 85);
      drain();

      for (p = 0; p < 8; p++) begin
         write_csr(CSR_SLOT_COUNT, phase_slots[p]);
         write_csr(CSR_BODY_LIMIT, phase_limit[p]);
         lim = phase_limit[p];
         steady = (p == 2 || p == 6);
         for (i = 0; i < 80; i++) begin
            if ((p == 1 || p == 5) && i == 20) hold_request = 1'b1;
            if (p == 4 && i == 40) drain();
            if ($urandom_range(0, 99) < phase_alloc[p]) begin
               act = ACT_ALLOC;
               size = ($urandom_range(0, 99) < 85) ? $urandom_range(0, lim)
                                                   : $urandom_range(0, 65535);
               idx = $urandom_range(0, 255);
            end else begin
               act = ACT_FREE;
               idx = ($urandom_range(0, 99) < 75) ? pool.any_busy_slot()
                                                  : $urandom_range(0, 255);
               size = $urandom_range(0, 65535);
            end
            issue(act, size, idx);
         end
         drain();
      end

      steady = 1'b0;
      repeat (20) @(posedge clock);
      if (pool.failed || pool.pending() != 0) begin
         $display("SCOREBOARD MISMATCH");
      end else begin
         $display("SCOREBOARD CLEAN");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== fixed_block_pool_next_fit.f =====
hw/rtl/fbpnf_pkg.sv
hw/rtl/fbpnf_flag_ram.sv
hw/rtl/fixed_block_pool_next_fit.sv
tb/sv/tb_fixed_block_pool_next_fit.sv
